### sv/space_vector_modulation_timing_top_assert.svh
// ----------------------------------------------------------------------------
// Space vector timing assertion macros
// Shared concurrent assertion forms for the sextant timing block.
// ----------------------------------------------------------------------------
`ifndef SPACE_VECTOR_MODULATION_TIMING_TOP_ASSERT_SVH
`define SPACE_VECTOR_MODULATION_TIMING_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SVMT_ASSERT_IMPLY(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cond) |-> (expr)) else $error(msg);

// The consequent must hold once the delay lat has passed after the antecedent.
`define SVMT_ASSERT_AFTER(label, cond, lat, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cond) |-> ##lat (expr)) else $error(msg);

`endif

### sv/svmt_pkg.sv
// ----------------------------------------------------------------------------
// Space vector timing package
// Widths, fixed-point constants and stage types shared by the pipeline.
// ----------------------------------------------------------------------------
package svmt_pkg;

	// Input sample width, Q2.(INPUT_WIDTH-2).
	localparam int INPUT_WIDTH = 16;
	// Fraction bits of the input format.
	localparam int FRAC = INPUT_WIDTH - 2;
	// 1/sqrt3 in Q30.
	localparam int K_W = 31;
	localparam logic signed [K_W-1:0] INV_SQRT3_Q30 = 31'sd619925131;
	// beta * K product width.
	localparam int BK_W = INPUT_WIDTH + K_W;
	// Width of the on-time sums in Q(FRAC+30).
	localparam int SUM_W = INPUT_WIDTH + 33;
	// Shift from Q(FRAC+30) down to Q25.
	localparam int SH = FRAC + 5;
	// On-time width in Q25.
	localparam int TW = SUM_W - SH;
	// Phase time width in Q26.
	localparam int PH_W = TW + 3;
	// Squared magnitude width.
	localparam int SQ_W = 2 * INPUT_WIDTH;
	// Output time width, 65536 means one period.
	localparam int OUT_W = 17;

	typedef enum logic [2:0] {
		SX_1 = 3'd1,
		SX_2 = 3'd2,
		SX_3 = 3'd3,
		SX_4 = 3'd4,
		SX_5 = 3'd5,
		SX_6 = 3'd6
	} sextant_t;

	// Beat leaving the sextant stages.
	typedef struct packed {
		logic                        vld;
		sextant_t                    sx;
		logic signed [INPUT_WIDTH-1:0] al;
		logic signed [BK_W-1:0]      bk;
	} sec_t;

	// Beat leaving the on-time stage.
	typedef struct packed {
		logic              vld;
		sextant_t          sx;
		logic signed [TW-1:0] ta;
		logic signed [TW-1:0] tb;
	} ont_t;

endpackage

### sv/svmt_sector.sv
// ----------------------------------------------------------------------------
// Sextant detection stages
// Takes magnitudes, squares them and finds the sextant of the vector.
// ----------------------------------------------------------------------------
module svmt_sector (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_vld,
	input  logic signed [svmt_pkg::INPUT_WIDTH-1:0]  alpha,
	input  logic signed [svmt_pkg::INPUT_WIDTH-1:0]  beta,
	output svmt_pkg::sec_t                           sec
);

	localparam int IW = svmt_pkg::INPUT_WIDTH;
	localparam int SQ_W = svmt_pkg::SQ_W;
	localparam int BK_W = svmt_pkg::BK_W;

	logic                   vld_s1, vld_s2, vld_s3;
	logic signed [IW-1:0]   al_s1, al_s2, al_s3;
	logic signed [IW-1:0]   be_s1;
	logic [IW-1:0]          aa_s1, bb_s1;
	logic [SQ_W-1:0]        a2_s2, b2_s2;
	logic signed [BK_W-1:0] bk_s2, bk_s3;
	svmt_pkg::sextant_t     sx_s3;
	logic [SQ_W+1:0]        a2x3;
	logic [SQ_W+1:0]        b2_ext;
	svmt_pkg::sextant_t     sx_next;

	// Valid bits travel with the beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage 1 registers the sample and its magnitudes.
	always_ff @(posedge clk) begin
		al_s1 <= alpha;
		be_s1 <= beta;
		aa_s1 <= alpha[IW-1] ? IW'(-alpha) : IW'(alpha);
		bb_s1 <= beta[IW-1] ? IW'(-beta) : IW'(beta);
	end

	// Stage 2 forms the squares and beta / sqrt3 in Q(FRAC+30).
	always_ff @(posedge clk) begin
		a2_s2 <= SQ_W'(aa_s1) * SQ_W'(aa_s1);
		b2_s2 <= SQ_W'(bb_s1) * SQ_W'(bb_s1);
		bk_s2 <= BK_W'(be_s1) * BK_W'(svmt_pkg::INV_SQRT3_Q30);
		al_s2 <= al_s1;
	end

	// Compare beta^2 against 3 alpha^2 and pick the sextant by quadrant.
	always_comb begin
		a2x3   = {2'b00, a2_s2} + {1'b0, a2_s2, 1'b0};
		b2_ext = {2'b00, b2_s2};
		if (!bk_s2[BK_W-1]) begin
			if (!al_s2[IW-1]) begin
				sx_next = (b2_ext > a2x3) ? svmt_pkg::SX_2 : svmt_pkg::SX_1;
			end else begin
				sx_next = (a2x3 > b2_ext) ? svmt_pkg::SX_3 : svmt_pkg::SX_2;
			end
		end else begin
			if (!al_s2[IW-1]) begin
				sx_next = (b2_ext > a2x3) ? svmt_pkg::SX_5 : svmt_pkg::SX_6;
			end else begin
				sx_next = (a2x3 > b2_ext) ? svmt_pkg::SX_4 : svmt_pkg::SX_5;
			end
		end
	end

	// Stage 3 holds the sextant with the operands for the on-times.
	always_ff @(posedge clk) begin
		sx_s3 <= sx_next;
		al_s3 <= al_s2;
		bk_s3 <= bk_s2;
	end

	assign sec.vld = vld_s3;
	assign sec.sx  = sx_s3;
	assign sec.al  = al_s3;
	assign sec.bk  = bk_s3;

endmodule

### sv/svmt_ontime.sv
// ----------------------------------------------------------------------------
// Active vector on-time stage
// Forms the two on-times of the sextant, floored to Q25.
// ----------------------------------------------------------------------------
module svmt_ontime (
	input  logic           clk,
	input  logic           arst_n,
	input  svmt_pkg::sec_t sec,
	output svmt_pkg::ont_t ont
);

	localparam int IW = svmt_pkg::INPUT_WIDTH;
	localparam int SUM_W = svmt_pkg::SUM_W;
	localparam int BK_W = svmt_pkg::BK_W;
	localparam int TW = svmt_pkg::TW;
	localparam int SH = svmt_pkg::SH;

	logic signed [SUM_W-1:0] a_ext, b_ext;
	logic signed [SUM_W-1:0] s_pos, s_dif, s_two;
	logic signed [SUM_W-1:0] sum_a, sum_b;
	logic signed [SUM_W-1:0] sh_a, sh_b;
	logic                    vld_s4;
	svmt_pkg::sextant_t      sx_s4;
	logic signed [TW-1:0]    ta_s4, tb_s4;

	// Alpha scaled by 2^30 and beta / sqrt3, both in Q(FRAC+30).
	assign a_ext = {{(SUM_W-IW-30){sec.al[IW-1]}}, sec.al, 30'b0};
	assign b_ext = {{(SUM_W-BK_W){sec.bk[BK_W-1]}}, sec.bk};
	assign s_pos = a_ext + b_ext;
	assign s_dif = a_ext - b_ext;
	assign s_two = b_ext <<< 1;

	// Select the on-time sums for the sextant.
	always_comb begin
		unique case (sec.sx)
			svmt_pkg::SX_1: begin
				sum_a = s_dif;
				sum_b = s_two;
			end
			svmt_pkg::SX_2: begin
				sum_a = -s_dif;
				sum_b = s_pos;
			end
			svmt_pkg::SX_3: begin
				sum_a = s_two;
				sum_b = -s_pos;
			end
			svmt_pkg::SX_4: begin
				sum_a = -s_two;
				sum_b = -s_dif;
			end
			svmt_pkg::SX_5: begin
				sum_a = -s_pos;
				sum_b = s_dif;
			end
			default: begin
				sum_a = s_pos;
				sum_b = -s_two;
			end
		endcase
		sh_a = sum_a >>> SH;
		sh_b = sum_b >>> SH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= sec.vld;
		end
	end

	// Stage 4 holds the floored on-times.
	always_ff @(posedge clk) begin
		sx_s4 <= sec.sx;
		ta_s4 <= sh_a[TW-1:0];
		tb_s4 <= sh_b[TW-1:0];
	end

	assign ont.vld = vld_s4;
	assign ont.sx  = sx_s4;
	assign ont.ta  = ta_s4;
	assign ont.tb  = tb_s4;

endmodule

### sv/svmt_phase.sv
// ----------------------------------------------------------------------------
// Phase time stages
// Builds centre-aligned phase times, then rounds, clamps and checks them.
// ----------------------------------------------------------------------------
module svmt_phase (
	input  logic                          clk,
	input  logic                          arst_n,
	input  svmt_pkg::ont_t                ont,
	output logic                          out_vld,
	output logic [svmt_pkg::OUT_W-1:0]    time_a,
	output logic [svmt_pkg::OUT_W-1:0]    time_b,
	output logic [svmt_pkg::OUT_W-1:0]    time_c,
	output logic [2:0]                    sx_out,
	output logic                          in_range
);

	localparam int TW = svmt_pkg::TW;
	localparam int PH_W = svmt_pkg::PH_W;
	localparam int OUT_W = svmt_pkg::OUT_W;
	localparam logic signed [PH_W-1:0] HALF_Q26 = PH_W'(33'sd33554432);
	localparam logic signed [PH_W-1:0] ONE_Q26  = PH_W'(33'sd67108864);
	localparam logic signed [PH_W-1:0] RND_Q26  = PH_W'(33'sd512);
	localparam logic signed [PH_W-1:0] ONE_Q16  = PH_W'(33'sd65536);

	logic signed [PH_W-1:0] ta_x, tb_x;
	logic signed [PH_W-1:0] first, mid, last;
	logic signed [PH_W-1:0] pa, pb, pc;
	logic                   vld_s5;
	svmt_pkg::sextant_t     sx_s5;
	logic signed [PH_W-1:0] pa_s5, pb_s5, pc_s5;
	logic                   vld_s6;
	logic [OUT_W-1:0]       ta_s6, tb_s6, tc_s6;
	logic [2:0]             sx_s6;
	logic                   ok_s6;

	// Round a Q26 time to Q16, half up, and clamp to one period.
	function automatic logic [OUT_W-1:0] to_q16(input logic signed [PH_W-1:0] q);
		logic signed [PH_W-1:0] r;
		r = (q + RND_Q26) >>> 10;
		if (r[PH_W-1]) begin
			to_q16 = '0;
		end else if (r > ONE_Q16) begin
			to_q16 = ONE_Q16[OUT_W-1:0];
		end else begin
			to_q16 = r[OUT_W-1:0];
		end
	endfunction

	function automatic logic in_unit(input logic signed [PH_W-1:0] q);
		in_unit = !q[PH_W-1] && (q <= ONE_Q26);
	endfunction

	// First phase gets the half zero time, the next ones add the on-times.
	// The later phases are formed directly from the half period so that the
	// three sums are computed side by side.
	assign ta_x  = {{(PH_W-TW){ont.ta[TW-1]}}, ont.ta};
	assign tb_x  = {{(PH_W-TW){ont.tb[TW-1]}}, ont.tb};
	assign first = HALF_Q26 - ta_x - tb_x;
	assign mid   = HALF_Q26 + ta_x - tb_x;
	assign last  = HALF_Q26 + ta_x + tb_x;

	// Route the three times to the phases by sextant.
	always_comb begin
		unique case (ont.sx)
			svmt_pkg::SX_1: begin
				pa = first; pb = mid;   pc = last;
			end
			svmt_pkg::SX_2: begin
				pb = first; pa = mid;   pc = last;
			end
			svmt_pkg::SX_3: begin
				pb = first; pc = mid;   pa = last;
			end
			svmt_pkg::SX_4: begin
				pc = first; pb = mid;   pa = last;
			end
			svmt_pkg::SX_5: begin
				pc = first; pa = mid;   pb = last;
			end
			default: begin
				pa = first; pc = mid;   pb = last;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s5 <= ont.vld;
			vld_s6 <= vld_s5;
		end
	end

	// Stage 5 holds the exact Q26 phase times.
	always_ff @(posedge clk) begin
		sx_s5 <= ont.sx;
		pa_s5 <= pa;
		pb_s5 <= pb;
		pc_s5 <= pc;
	end

	// Stage 6 is the output register.
	always_ff @(posedge clk) begin
		ta_s6 <= to_q16(pa_s5);
		tb_s6 <= to_q16(pb_s5);
		tc_s6 <= to_q16(pc_s5);
		sx_s6 <= sx_s5;
		ok_s6 <= in_unit(pa_s5) && in_unit(pb_s5) && in_unit(pc_s5);
	end

	assign out_vld  = vld_s6;
	assign time_a   = ta_s6;
	assign time_b   = tb_s6;
	assign time_c   = tc_s6;
	assign sx_out   = sx_s6;
	assign in_range = ok_s6;

endmodule

### sv/space_vector_modulation_timing_top.sv
// ----------------------------------------------------------------------------
// Space vector PWM sextant timing, top level
// Six-stage pipeline from an (alpha, beta) sample to phase switching times.
// ----------------------------------------------------------------------------
// A sample is taken on every clock in which start is high; busy is always low,
// so a new sample may follow in the next cycle. Each sample gives exactly one
// result, marked by done for a single cycle, in the order the samples came in.
// The six register stages are magnitude, squaring and the beta / sqrt3
// multiply, sextant compare, on-time sums, phase sums, and final rounding and
// clamping. The result ports hold a beat for one cycle only and the receiver
// must take it then.
module space_vector_modulation_timing_top (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	output logic                                     busy,
	input  logic signed [svmt_pkg::INPUT_WIDTH-1:0]  alpha_voltage,
	input  logic signed [svmt_pkg::INPUT_WIDTH-1:0]  beta_voltage,
	output logic                                     done,
	output logic [svmt_pkg::OUT_W-1:0]               phase_a_time,
	output logic [svmt_pkg::OUT_W-1:0]               phase_b_time,
	output logic [svmt_pkg::OUT_W-1:0]               phase_c_time,
	output logic [2:0]                               sextant,
	output logic                                     times_valid
);

	`include "space_vector_modulation_timing_top_assert.svh"

	svmt_pkg::sec_t sec;
	svmt_pkg::ont_t ont;
	logic           take;
	logic           sx_ok;

	// The pipeline never stalls, so every start beat is taken.
	assign busy = 1'b0;
	assign take = start && !busy;

	svmt_sector u_sector (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (take),
		.alpha  (alpha_voltage),
		.beta   (beta_voltage),
		.sec    (sec)
	);

	svmt_ontime u_ontime (
		.clk    (clk),
		.arst_n (arst_n),
		.sec    (sec),
		.ont    (ont)
	);

	svmt_phase u_phase (
		.clk      (clk),
		.arst_n   (arst_n),
		.ont      (ont),
		.out_vld  (done),
		.time_a   (phase_a_time),
		.time_b   (phase_b_time),
		.time_c   (phase_c_time),
		.sx_out   (sextant),
		.in_range (times_valid)
	);

	// The sextant on the result ports lies between the first and the last code.
	assign sx_ok = (sextant >= svmt_pkg::SX_1) && (sextant <= svmt_pkg::SX_6);

	// Every accepted beat comes out on done once it has passed the pipeline.
	`SVMT_ASSERT_AFTER(a_latency, take, 6, done, "accepted beat did not complete on time")

	// A completed beat always carries a sextant from one to six.
	`SVMT_ASSERT_IMPLY(a_sextant, done, sx_ok, "sextant out of range")

	// Nothing completes without a beat having been accepted into the pipeline.
	`SVMT_ASSERT_IMPLY(a_no_phantom, done, $past(take, 6), "result without accepted beat")

endmodule
